// ===== design/klg_pkg.sv =====
// Shared types, codes and widths for the leapfrog grid unit.
package klg_pkg;

    localparam int GRID_POINTS_DEF = 64;
    localparam int UPDATE_STAGES   = 5;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 6;
    localparam int COEF_W  = 32;
    localparam int D_W     = 35;   // stencil difference, exact
    localparam int PROD_W  = 53;   // one partial product plus rounding bias
    localparam int TERM_W  = 40;   // product shifted back to Q12.20
    localparam int FORCE_W = 41;   // difference of two terms
    localparam int SUM_W   = 42;   // update before clamping

    localparam logic signed [PROD_W-1:0] Q30_ROUND = PROD_W'(1 << 29);

    localparam logic [1:0] CFG_LAP       = 2'd0;
    localparam logic [1:0] CFG_MASS      = 2'd1;
    localparam logic [1:0] CFG_STEP_SIZE = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_KICK = 2'd1,
        OP_STEP = 2'd2,
        OP_READ = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        PT_PASS,
        PT_LOAD,
        PT_HALF,
        PT_FULL,
        PT_DRIFT
    } point_op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] phi;
        logic signed [DATA_W-1:0] pi;
    } point_t;

    typedef struct packed {
        logic [COEF_W-1:0] lap;
        logic [COEF_W-1:0] mass;
        logic [COEF_W-1:0] step;
    } coeff_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic [INDEX_W-1:0]       point_index;
        logic signed [DATA_W-1:0] field_value;
        logic signed [DATA_W-1:0] momentum_value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] field_out;
        logic signed [DATA_W-1:0] momentum_out;
        logic                     saturated;
    } result_t;

endpackage

// ===== design/klg_cell.sv =====
// One ring cell holding the field and momentum of a single grid point.
module klg_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  klg_pkg::point_t shift_in,
    output klg_pkg::point_t held
);

    klg_pkg::point_t point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg <= '0;
        end
        else if (shift_en)
        begin
            point_reg <= shift_in;
        end
    end

    assign held = point_reg;

endmodule

// ===== design/klg_update.sv =====
// Five-stage update pipeline that closes the ring: kick, half kick or drift of one point.
module klg_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  klg_pkg::point_op_t                op_in,
    input  klg_pkg::point_t                   pt_in,
    input  logic signed [klg_pkg::DATA_W-1:0] phi_next,
    input  logic signed [klg_pkg::DATA_W-1:0] phi_prev,
    input  klg_pkg::coeff_t                   coeff,
    output klg_pkg::point_t                   pt_out,
    output logic                              sat_out
);

    localparam int D_W     = klg_pkg::D_W;
    localparam int PROD_W  = klg_pkg::PROD_W;
    localparam int TERM_W  = klg_pkg::TERM_W;
    localparam int FORCE_W = klg_pkg::FORCE_W;
    localparam int SUM_W   = klg_pkg::SUM_W;
    localparam int COEF_W  = klg_pkg::COEF_W;
    localparam int HALF_W  = COEF_W / 2;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);
    localparam logic signed [FORCE_W-1:0] FORCE_ONE = FORCE_W'(1);

    // Stage 1: operands and the stencil difference.
    klg_pkg::point_op_t       s1_op_reg;
    klg_pkg::point_t          s1_pt_reg;
    logic signed [D_W-1:0]    s1_d_reg;
    logic signed [D_W-1:0]    s1_d_next;

    assign s1_d_next = D_W'(phi_next) + D_W'(phi_prev) - (D_W'(pt_in.phi) <<< 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_op_reg <= klg_pkg::PT_PASS;
        end
        else if (en)
        begin
            s1_op_reg <= op_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pt_reg <= pt_in;
            s1_d_reg  <= s1_d_next;
        end
    end

    // Stage 2: the coefficient is split in halves so each product stays narrow.
    logic                     s1_kick;
    logic signed [D_W-1:0]    op_a;
    logic signed [D_W-1:0]    op_b;
    logic [COEF_W-1:0]        coef_a;
    logic [COEF_W-1:0]        coef_b;
    logic signed [PROD_W-1:0] hi_a_next;
    logic signed [PROD_W-1:0] lo_a_next;
    logic signed [PROD_W-1:0] hi_b_next;
    logic signed [PROD_W-1:0] lo_b_next;

    assign s1_kick = (s1_op_reg == klg_pkg::PT_HALF) || (s1_op_reg == klg_pkg::PT_FULL);
    assign op_a    = s1_kick ? s1_d_reg : D_W'(s1_pt_reg.pi);
    assign coef_a  = s1_kick ? coeff.lap : coeff.step;
    assign op_b    = D_W'(s1_pt_reg.phi);
    assign coef_b  = s1_kick ? coeff.mass : '0;

    assign hi_a_next = op_a * $signed({1'b0, coef_a[COEF_W-1:HALF_W]});
    assign lo_a_next = op_a * $signed({1'b0, coef_a[HALF_W-1:0]}) + klg_pkg::Q30_ROUND;
    assign hi_b_next = op_b * $signed({1'b0, coef_b[COEF_W-1:HALF_W]});
    assign lo_b_next = op_b * $signed({1'b0, coef_b[HALF_W-1:0]}) + klg_pkg::Q30_ROUND;

    klg_pkg::point_op_t       s2_op_reg;
    klg_pkg::point_t          s2_pt_reg;
    logic signed [PROD_W-1:0] s2_hi_a_reg;
    logic signed [PROD_W-1:0] s2_lo_a_reg;
    logic signed [PROD_W-1:0] s2_hi_b_reg;
    logic signed [PROD_W-1:0] s2_lo_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_op_reg <= klg_pkg::PT_PASS;
        end
        else if (en)
        begin
            s2_op_reg <= s1_op_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pt_reg   <= s1_pt_reg;
            s2_hi_a_reg <= hi_a_next;
            s2_lo_a_reg <= lo_a_next;
            s2_hi_b_reg <= hi_b_next;
            s2_lo_b_reg <= lo_b_next;
        end
    end

    // Stage 3: recombine the halves and shift back by 30 with round to nearest.
    logic signed [PROD_W-1:0] sum_a;
    logic signed [PROD_W-1:0] sum_b;
    logic signed [PROD_W-1:0] shr_a;
    logic signed [PROD_W-1:0] shr_b;

    assign sum_a = s2_hi_a_reg + (s2_lo_a_reg >>> HALF_W);
    assign sum_b = s2_hi_b_reg + (s2_lo_b_reg >>> HALF_W);
    assign shr_a = sum_a >>> (30 - HALF_W);
    assign shr_b = sum_b >>> (30 - HALF_W);

    klg_pkg::point_op_t       s3_op_reg;
    klg_pkg::point_t          s3_pt_reg;
    logic signed [TERM_W-1:0] s3_term_a_reg;
    logic signed [TERM_W-1:0] s3_term_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_op_reg <= klg_pkg::PT_PASS;
        end
        else if (en)
        begin
            s3_op_reg <= s2_op_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_pt_reg     <= s2_pt_reg;
            s3_term_a_reg <= shr_a[TERM_W-1:0];
            s3_term_b_reg <= shr_b[TERM_W-1:0];
        end
    end

    // Stage 4: force, halved with ties toward plus infinity for the initial kick; drift takes the step term.
    logic signed [FORCE_W-1:0] diff;
    logic signed [FORCE_W-1:0] half_diff;
    logic signed [FORCE_W-1:0] delta_next;

    assign diff      = FORCE_W'(s3_term_a_reg) - FORCE_W'(s3_term_b_reg);
    assign half_diff = (diff + FORCE_ONE) >>> 1;

    always_comb
    begin
        case (s3_op_reg)
            klg_pkg::PT_HALF:  delta_next = half_diff;
            klg_pkg::PT_FULL:  delta_next = diff;
            klg_pkg::PT_DRIFT: delta_next = FORCE_W'(s3_term_a_reg);
            default:           delta_next = '0;
        endcase
    end

    klg_pkg::point_op_t        s4_op_reg;
    klg_pkg::point_t           s4_pt_reg;
    logic signed [FORCE_W-1:0] s4_delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_op_reg <= klg_pkg::PT_PASS;
        end
        else if (en)
        begin
            s4_op_reg <= s3_op_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_pt_reg    <= s3_pt_reg;
            s4_delta_reg <= delta_next;
        end
    end

    // Stage 5: accumulate into pi or phi and clamp to 32 bits.
    logic                       s4_drift;
    logic                       s4_update;
    logic signed [SUM_W-1:0]    base;
    logic signed [SUM_W-1:0]    total;
    logic signed [klg_pkg::DATA_W-1:0] clamped;
    logic                       clamp_hit;
    klg_pkg::point_t            pt_next;

    assign s4_drift  = (s4_op_reg == klg_pkg::PT_DRIFT);
    assign s4_update = s4_drift || (s4_op_reg == klg_pkg::PT_HALF)
                       || (s4_op_reg == klg_pkg::PT_FULL);
    assign base      = s4_drift ? SUM_W'(s4_pt_reg.phi) : SUM_W'(s4_pt_reg.pi);
    assign total     = base + SUM_W'(s4_delta_reg);

    always_comb
    begin
        clamp_hit = 1'b0;
        clamped   = total[klg_pkg::DATA_W-1:0];
        if (total > SAT_MAX)
        begin
            clamp_hit = 1'b1;
            clamped   = SAT_MAX[klg_pkg::DATA_W-1:0];
        end
        else if (total < SAT_MIN)
        begin
            clamp_hit = 1'b1;
            clamped   = SAT_MIN[klg_pkg::DATA_W-1:0];
        end

        pt_next = s4_pt_reg;
        if (s4_drift)
        begin
            pt_next.phi = clamped;
        end
        else if (s4_update)
        begin
            pt_next.pi = clamped;
        end
    end

    klg_pkg::point_t s5_pt_reg;
    logic            s5_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_sat_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_sat_reg <= s4_update && clamp_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_pt_reg <= pt_next;
        end
    end

    assign pt_out  = s5_pt_reg;
    assign sat_out = s5_sat_reg;

endmodule

// ===== design/klein_gordon_leapfrog_grid_unit.sv =====
// Top level: ring of grid cells closed through the update pipeline, with command sequencer.
// In a sweep the ring rotates once through the update pipeline.
// busy stays high for one sweep on load, read and initial kick, and on a step with only the
// drift due; a step that kicks runs two sweeps. The next command is taken only while busy
// is low. A read result strobes on done in the cycle after its sweep and cannot be stalled
// by the receiver.
// Reset clears all grid points, the coefficients, the pending drift and the sticky flag.
module klein_gordon_leapfrog_grid_unit #(
    parameter int GRID_POINTS = klg_pkg::GRID_POINTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  klg_pkg::cmd_t              cmd,
    output logic                       done,
    output klg_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [klg_pkg::COEF_W-1:0] cfg_data
);

    localparam int RING   = GRID_POINTS + klg_pkg::UPDATE_STAGES;
    localparam int CNT_W  = $clog2(RING);
    localparam int CMP_W  = (CNT_W > klg_pkg::INDEX_W) ? CNT_W : klg_pkg::INDEX_W;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    state_t                       state_reg;
    logic [CNT_W-1:0]             t_reg;
    klg_pkg::opcode_t             op_reg;
    logic [klg_pkg::INDEX_W-1:0]  idx_reg;
    klg_pkg::point_t              load_pt_reg;
    klg_pkg::point_op_t           sweep_op_reg;
    logic                         pending_reg;
    logic                         sat_seen_reg;
    klg_pkg::point_t              read_pt_reg;
    logic                         done_reg;
    klg_pkg::result_t             result_reg;
    klg_pkg::coeff_t              coeff_reg;
    logic signed [klg_pkg::DATA_W-1:0] prev_phi_reg;
    logic signed [klg_pkg::DATA_W-1:0] first_phi_reg;

    logic                         shift_en;
    logic                         live;
    logic                         hit;
    logic                         idx_ok;
    logic                         sweep_last;
    klg_pkg::point_op_t           entry_op;
    klg_pkg::point_t              entry_pt;
    logic signed [klg_pkg::DATA_W-1:0] phi_prev;
    logic signed [klg_pkg::DATA_W-1:0] phi_next;
    klg_pkg::point_t              upd_pt;
    logic                         upd_sat;
    klg_pkg::point_op_t           sweep_op_next;

    klg_pkg::point_t cell_q [GRID_POINTS];
    klg_pkg::point_t cell_d [GRID_POINTS];

    assign busy      = (state_reg != ST_IDLE);
    assign shift_en  = (state_reg == ST_SWEEP);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign live       = CMP_W'(t_reg) < CMP_W'(GRID_POINTS);
    assign hit        = CMP_W'(t_reg) == CMP_W'(idx_reg);
    assign idx_ok     = CMP_W'(idx_reg) < CMP_W'(GRID_POINTS);
    assign sweep_last = (t_reg == CNT_W'(RING - 1));

    // The ring starts each sweep in its home position, so the left neighbor of
    // point zero is the last cell and the right neighbor of the last point is
    // the first point's value saved on entry.
    assign phi_prev = (t_reg == '0) ? cell_q[GRID_POINTS-1].phi : prev_phi_reg;
    assign phi_next = (t_reg == CNT_W'(GRID_POINTS - 1)) ? first_phi_reg : cell_q[1].phi;

    always_comb
    begin
        entry_op = live ? sweep_op_reg : klg_pkg::PT_PASS;
        entry_pt = cell_q[0];
        if (live && hit && (op_reg == klg_pkg::OP_LOAD))
        begin
            entry_op = klg_pkg::PT_LOAD;
            entry_pt = load_pt_reg;
        end
    end

    for (genvar k = 0; k < GRID_POINTS; k++)
    begin : g_cell
        if (k == GRID_POINTS - 1)
        begin : g_tail
            assign cell_d[k] = upd_pt;
        end
        else
        begin : g_body
            assign cell_d[k] = cell_q[k+1];
        end

        klg_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .shift_in (cell_d[k]),
            .held     (cell_q[k])
        );
    end

    klg_update u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (shift_en),
        .op_in    (entry_op),
        .pt_in    (entry_pt),
        .phi_next (phi_next),
        .phi_prev (phi_prev),
        .coeff    (coeff_reg),
        .pt_out   (upd_pt),
        .sat_out  (upd_sat)
    );

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            prev_phi_reg <= cell_q[0].phi;
            if (t_reg == '0)
            begin
                first_phi_reg <= cell_q[0].phi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                klg_pkg::CFG_LAP:       coeff_reg.lap  <= cfg_data;
                klg_pkg::CFG_MASS:      coeff_reg.mass <= cfg_data;
                klg_pkg::CFG_STEP_SIZE: coeff_reg.step <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_seen_reg <= 1'b0;
        end
        else if (shift_en && upd_sat)
        begin
            sat_seen_reg <= 1'b1;
        end
    end

    always_comb
    begin
        unique case (cmd.opcode) inside
            klg_pkg::OP_LOAD, klg_pkg::OP_READ: sweep_op_next = klg_pkg::PT_PASS;
            klg_pkg::OP_KICK: sweep_op_next = klg_pkg::PT_HALF;
            klg_pkg::OP_STEP: sweep_op_next = pending_reg ? klg_pkg::PT_DRIFT
                                                          : klg_pkg::PT_FULL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            t_reg        <= '0;
            pending_reg  <= 1'b0;
            done_reg     <= 1'b0;
            op_reg       <= klg_pkg::OP_LOAD;
            sweep_op_reg <= klg_pkg::PT_PASS;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        op_reg           <= cmd.opcode;
                        idx_reg          <= cmd.point_index;
                        load_pt_reg.phi  <= cmd.field_value;
                        load_pt_reg.pi   <= cmd.momentum_value;
                        sweep_op_reg     <= sweep_op_next;
                        t_reg            <= '0;
                        state_reg        <= ST_SWEEP;
                        if (cmd.opcode == klg_pkg::OP_KICK)
                        begin
                            pending_reg <= 1'b1;
                        end
                        else if (cmd.opcode == klg_pkg::OP_STEP)
                        begin
                            pending_reg <= 1'b0;
                        end
                    end
                end
                ST_SWEEP:
                begin
                    if (live && hit && (op_reg == klg_pkg::OP_READ))
                    begin
                        read_pt_reg <= cell_q[0];
                    end
                    if (sweep_last)
                    begin
                        t_reg <= '0;
                        if ((op_reg == klg_pkg::OP_STEP) && (sweep_op_reg == klg_pkg::PT_FULL))
                        begin
                            sweep_op_reg <= klg_pkg::PT_DRIFT;
                            done_reg     <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                            done_reg  <= (op_reg == klg_pkg::OP_READ);
                            if (op_reg == klg_pkg::OP_READ)
                            begin
                                result_reg.field_out    <= idx_ok ? read_pt_reg.phi : '0;
                                result_reg.momentum_out <= idx_ok ? read_pt_reg.pi : '0;
                                result_reg.saturated    <= sat_seen_reg;
                            end
                        end
                    end
                    else
                    begin
                        t_reg    <= t_reg + CNT_W'(1);
                        done_reg <= 1'b0;
                    end
                end
            endcase
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a sweep is still running");

    a_done_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (op_reg == klg_pkg::OP_READ))
        else $error("result strobe for a command other than read");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start a sweep");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (t_reg <= CNT_W'(RING - 1)))
        else $error("sweep counter ran past the ring length");

    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(sat_seen_reg))
        else $error("saturation flag cleared without reset");

endmodule
